// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRCSUM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcsum check failed");

// Next-cycle implication.
`define CRCSUM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crcsum check failed");

`endif

// ===== sv/crcsum_pkg.sv =====
`default_nettype none

package crcsum_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;
  localparam logic [31:0] SUM_INIT   = 32'h00000000;

  // One image byte and its end-of-image flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } crcsum_item_t;

  // Final trailer values
  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] sum;
  } crcsum_result_t;

  // Reflected CRC-32 over one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h000000, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Sum of the four bytes of a word
  function automatic logic [31:0] byte_total(input logic [31:0] w);
    logic [9:0] t;
    t = {2'b00, w[31:24]} + {2'b00, w[23:16]} + {2'b00, w[15:8]} + {2'b00, w[7:0]};
    return {22'h000000, t};
  endfunction

endpackage

`default_nettype wire

// ===== sv/crcsum_in_stage.sv =====
`default_nettype none

module crcsum_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [7:0]            in_data,
  input  wire logic                  in_last,
  input  wire logic                  advance,
  output logic                       in_stall,
  output logic                       stage_valid,
  output crcsum_pkg::crcsum_item_t   stage_item
);
  import crcsum_pkg::*;

  logic load;

  // Stage is free when empty or when its byte moves on this cycle
  assign in_stall = stage_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_item.data <= in_data;
      stage_item.last <= in_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crcsum_core.sv =====
`default_nettype none

module crcsum_core (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire crcsum_pkg::crcsum_item_t item,
  output crcsum_pkg::crcsum_result_t   result
);
  import crcsum_pkg::*;

  logic [31:0] crc_running;
  logic [31:0] sum_running;
  logic [31:0] crc_next;
  logic [31:0] sum_next;
  logic [31:0] crc_final;

  // Fold the byte into both running values
  always_comb begin
    crc_next  = crc_byte(crc_running, item.data);
    sum_next  = sum_running + {24'h000000, item.data};
    crc_final = crc_next ^ CRC_XOROUT;
  end

  // Trailer: inverted CRC, and its bytes added to the sum
  assign result.crc = crc_final;
  assign result.sum = sum_next + byte_total(crc_final);

  // Running state; back to start values after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running <= CRC_INIT;
      sum_running <= SUM_INIT;
    end else if (fire) begin
      if (item.last) begin
        crc_running <= CRC_INIT;
        sum_running <= SUM_INIT;
      end else begin
        crc_running <= crc_next;
        sum_running <= sum_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/crcsum_out_stage.sv =====
`default_nettype none

module crcsum_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire crcsum_pkg::crcsum_result_t result_in,
  input  wire logic                      out_stall,
  output logic                           out_free,
  output logic                           out_valid,
  output logic [31:0]                    out_crc,
  output logic [31:0]                    out_sum
);
  import crcsum_pkg::*;

  // Register can take a request when empty or being drained
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      out_crc <= result_in.crc;
      out_sum <= result_in.sum;
    end
  end

endmodule

`default_nettype wire

// ===== sv/crc32_and_byte_sum_trailer.sv =====
// CRC-32 (reflected, polynomial EDB88320, preset all ones, inverted at the end)
// and 32-bit wrapping byte sum over an image streamed one byte per request.
// The byte flagged last_byte closes the image: one result then carries the
// final CRC and the byte sum plus the four CRC bytes, and both running values
// restart for the next image. One byte is taken every cycle unless a last byte
// waits for the result register. A last byte is registered in the input stage
// when it is accepted, and the CRC/sum update loads the result register once
// that register is free. Bytes keep flowing while a result waits; only a last
// byte waits for the result register.
`default_nettype none
`include "assert_macros.svh"

module crc32_and_byte_sum_trailer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      crc_value,
  output logic [31:0]      sum_value
);
  import crcsum_pkg::*;

  logic           stage_valid;
  crcsum_item_t   stage_item;
  crcsum_result_t core_result;
  logic           out_free;
  logic           advance;
  logic           fire;
  logic           res_load;
  logic           res_busy;

  // A non-last byte always moves on; a last byte needs the result register
  assign advance  = !stage_item.last || out_free;
  assign fire     = stage_valid && advance;
  assign res_load = fire && stage_item.last;

  // Result register holds a request that the receiver stalls
  assign res_busy = result_valid && result_stall;

  crcsum_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (byte_valid),
    .in_data     (data_byte),
    .in_last     (last_byte),
    .advance     (advance),
    .in_stall    (byte_stall),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  crcsum_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .result (core_result)
  );

  crcsum_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .result_in (core_result),
    .out_stall (result_stall),
    .out_free  (out_free),
    .out_valid (result_valid),
    .out_crc   (crc_value),
    .out_sum   (sum_value)
  );

  // Upstream only waits behind a last byte blocked by a pending result
  `CRCSUM_ASSERT_IMPLY(a_stall_cause, byte_stall, stage_valid && stage_item.last && res_busy)
  // A processed last byte shows up as a result next cycle
  `CRCSUM_ASSERT_NEXT(a_result_follows, res_load, result_valid)
  // A pending result is never overwritten
  `CRCSUM_ASSERT_IMPLY(a_no_overwrite, res_busy, !res_load)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import crcsum_pkg::*;

  localparam int IMAGE_BYTES = 1750;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    HOLD_NONE,
    HOLD_HALF,
    HOLD_LONG,
    HOLD_RARE
  } hold_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] crc_value;
  logic [31:0] sum_value;

  crcsum_item_t   image_bytes[$];
  crcsum_result_t trailer_due[$];

  // running state of the predicted trailer
  logic [31:0] crc_acc = CRC_INIT;
  logic [31:0] sum_acc = SUM_INIT;

  int mismatches = 0;
  int cycle_count = 0;

  crc32_and_byte_sum_trailer i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .crc_value    (crc_value),
    .sum_value    (sum_value)
  );

  always #5 clk = ~clk;

  // reflected CRC-32, one input bit per shift, LSB first
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // fold one accepted byte; the last byte closes the image
  task automatic fold_image_byte(input logic [7:0] b, input logic is_last);
    crcsum_result_t trailer;
    logic [31:0]    crc_final;
    crc_acc = crc_shift_byte(crc_acc, b);
    sum_acc = sum_acc + {24'h0, b};
    if (is_last) begin
      crc_final = crc_acc ^ CRC_XOROUT;
      trailer.crc = crc_final;
      trailer.sum = sum_acc + {24'h0, crc_final[31:24]} + {24'h0, crc_final[23:16]}
                  + {24'h0, crc_final[15:8]} + {24'h0, crc_final[7:0]};
      trailer_due.push_back(trailer);
      crc_acc = CRC_INIT;
      sum_acc = SUM_INIT;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic is_last);
    crcsum_item_t item;
    item.data = b;
    item.last = is_last;
    image_bytes.push_back(item);
  endtask

  // sender: bursts of requests with random gaps in between
  always @(posedge clk) begin
    int  burst_left;
    int  gap_left;
    logic fire;
    if (rst) begin
      byte_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      fire = byte_valid && !byte_stall;
      if (fire) begin
        fold_image_byte(data_byte, last_byte);
        void'(image_bytes.pop_front());
      end
      // a stalled request holds its payload
      if (!byte_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_valid <= 1'b0;
        end else if (image_bytes.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
          end
          byte_valid <= 1'b1;
          data_byte <= image_bytes[0].data;
          last_byte <= image_bytes[0].last;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check trailers and stall in changing modes
  always @(posedge clk) begin
    hold_mode_t     hold_mode;
    int             hold_left;
    crcsum_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      hold_mode = HOLD_NONE;
      hold_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (trailer_due.size() == 0) begin
          $display("%0t: unexpected result crc_value %08h sum_value %08h",
                   $time, crc_value, sum_value);
          mismatches++;
        end else begin
          want = trailer_due.pop_front();
          if (crc_value !== want.crc) begin
            $display("%0t: crc_value expected %08h actual %08h", $time, want.crc, crc_value);
            mismatches++;
          end
          if (sum_value !== want.sum) begin
            $display("%0t: sum_value expected %08h actual %08h", $time, want.sum, sum_value);
            mismatches++;
          end
        end
      end
      if (cycle_count % 200 == 0) begin
        hold_mode = hold_mode_t'($urandom_range(0, 3));
      end
      case (hold_mode)
        HOLD_NONE: begin
          result_stall <= 1'b0;
        end
        HOLD_HALF: begin
          result_stall <= 1'($urandom_range(0, 1));
        end
        HOLD_LONG: begin
          // long stall runs, each followed by a short release
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 16);
          end
          hold_left--;
          result_stall <= (hold_left > 2);
        end
        default: begin
          result_stall <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;

    // one-byte images at both extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    // the classic check string "123456789"
    for (int i = 1; i <= 9; i++) begin
      queue_byte(8'h30 + i[7:0], i == 9);
    end
    // all-ones image
    for (int i = 0; i < 8; i++) begin
      queue_byte(8'hFF, i == 7);
    end
    // alternating bit patterns
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);

    // random images, mostly short, runs of one-byte images included
    while (image_bytes.size() < IMAGE_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        len = 1;
      end else if (pick <= 7) begin
        len = $urandom_range(2, 16);
      end else if (pick == 8) begin
        len = $urandom_range(17, 64);
      end else begin
        len = $urandom_range(65, 200);
      end
      for (int k = 0; k < len; k++) begin
        queue_byte(8'($urandom_range(0, 255)), k == len - 1);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (image_bytes.size() != 0 || trailer_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
